### hw/rtl/cau_pkg.sv
// ============================================================================
// Complex arithmetic unit package
// Shared widths, operation and status codes, stage payload types and the
// saturation helper used by the pipeline modules.
// ============================================================================
package cau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  // Derived widths.
  localparam int PROD_W   = 2 * DATA_WIDTH;            // one operand product
  localparam int SUM_W    = PROD_W + 1;                // sum of two products
  localparam int SAT_IN_W = PROD_W + 2;                // widest value to saturate
  localparam int QBITS    = DATA_WIDTH + 1;            // quotient bits per divide
  localparam int NUM_W    = PROD_W + FRAC_BITS + 1;    // scaled dividend plus half
  localparam int REM_W    = PROD_W + QBITS;            // partial remainder
  localparam int DIV_LAT  = QBITS + 1;                 // divider stages
  localparam int SQRT_LAT = DATA_WIDTH + 2;            // square root stages

  localparam logic signed [SAT_IN_W-1:0] VAL_MAX =
    SAT_IN_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic signed [SAT_IN_W-1:0] VAL_MIN = -VAL_MAX - SAT_IN_W'(1);
  localparam logic signed [SAT_IN_W-1:0] HALF_LSB =
    (FRAC_BITS > 0) ? SAT_IN_W'(64'd1 << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : '0;

  // Operation codes carried in the input kind field.
  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_MOD  = 3'd5
  } func_t;

  // Result status codes.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  // Saturated value with its clip flag.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] val;
    logic                         clip;
  } sat_t;

  // Front end results that travel down the long pipeline beside the divider.
  typedef struct packed {
    logic [2:0]                   op;
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
    logic                         clip;
    logic                         dz;
  } simple_t;

  // Everything the front end hands to the back end.
  typedef struct packed {
    simple_t                 simple;
    logic signed [SUM_W-1:0] num_re;
    logic signed [SUM_W-1:0] num_im;
    logic [PROD_W-1:0]       den;
  } front_out_t;

  // Clip a wide signed value to the data range.
  function automatic sat_t sat(input logic signed [SAT_IN_W-1:0] x);
    sat_t s;
    if (x > VAL_MAX) begin
      s.val  = VAL_MAX[DATA_WIDTH-1:0];
      s.clip = 1'b1;
    end else if (x < VAL_MIN) begin
      s.val  = VAL_MIN[DATA_WIDTH-1:0];
      s.clip = 1'b1;
    end else begin
      s.val  = x[DATA_WIDTH-1:0];
      s.clip = 1'b0;
    end
    return s;
  endfunction

endpackage

### hw/rtl/cau_front.sv
// ============================================================================
// Complex arithmetic front end
// Two stages: the operand products, then the sums, rounding and saturation
// for add, subtract, multiply and conjugate, and the divide and modulus terms.
// ============================================================================
module cau_front (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [2:0]                           op,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] ar,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] ai,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] br,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] bi,
  output cau_pkg::front_out_t                  fout
);

  logic [2:0]                           op1;
  logic signed [cau_pkg::DATA_WIDTH-1:0] ar1, ai1, br1, bi1;
  logic signed [cau_pkg::PROD_W-1:0]     p_rr, p_ii, p_ir, p_ri;
  logic [cau_pkg::PROD_W-1:0]            sq0, sq1;
  logic signed [cau_pkg::DATA_WIDTH-1:0] x0, x1;

  // Modulus squares the first operand; divide squares the second.
  assign x0 = (op == cau_pkg::OP_MOD) ? ar : br;
  assign x1 = (op == cau_pkg::OP_MOD) ? ai : bi;

  // Product stage.
  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= op;
      ar1  <= ar;
      ai1  <= ai;
      br1  <= br;
      bi1  <= bi;
      p_rr <= ar * br;
      p_ii <= ai * bi;
      p_ir <= ai * br;
      p_ri <= ar * bi;
      sq0  <= cau_pkg::PROD_W'(x0 * x0);
      sq1  <= cau_pkg::PROD_W'(x1 * x1);
    end
  end

  cau_pkg::sat_t                        s_re, s_im;
  cau_pkg::front_out_t                  fnext;
  logic signed [cau_pkg::SAT_IN_W-1:0]  m_re, m_im;
  logic [cau_pkg::PROD_W-1:0]           den;

  // Sum stage: simple results and the divide and modulus terms.
  always_comb begin
    m_re = (cau_pkg::SAT_IN_W'(p_rr) - cau_pkg::SAT_IN_W'(p_ii) + cau_pkg::HALF_LSB)
           >>> cau_pkg::FRAC_BITS;
    m_im = (cau_pkg::SAT_IN_W'(p_ir) + cau_pkg::SAT_IN_W'(p_ri) + cau_pkg::HALF_LSB)
           >>> cau_pkg::FRAC_BITS;
    den  = sq0 + sq1;
    s_re = '0;
    s_im = '0;
    case (op1)
      cau_pkg::OP_ADD: begin
        s_re = cau_pkg::sat(cau_pkg::SAT_IN_W'(ar1) + cau_pkg::SAT_IN_W'(br1));
        s_im = cau_pkg::sat(cau_pkg::SAT_IN_W'(ai1) + cau_pkg::SAT_IN_W'(bi1));
      end
      cau_pkg::OP_SUB: begin
        s_re = cau_pkg::sat(cau_pkg::SAT_IN_W'(ar1) - cau_pkg::SAT_IN_W'(br1));
        s_im = cau_pkg::sat(cau_pkg::SAT_IN_W'(ai1) - cau_pkg::SAT_IN_W'(bi1));
      end
      cau_pkg::OP_MUL: begin
        s_re = cau_pkg::sat(m_re);
        s_im = cau_pkg::sat(m_im);
      end
      cau_pkg::OP_CONJ: begin
        s_re = cau_pkg::sat(cau_pkg::SAT_IN_W'(ar1));
        s_im = cau_pkg::sat(-cau_pkg::SAT_IN_W'(ai1));
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    fnext.simple.op   = op1;
    fnext.simple.re   = s_re.val;
    fnext.simple.im   = s_im.val;
    fnext.simple.clip = s_re.clip | s_im.clip;
    fnext.simple.dz   = (den == '0);
    fnext.num_re      = cau_pkg::SUM_W'(p_rr) + cau_pkg::SUM_W'(p_ii);
    fnext.num_im      = cau_pkg::SUM_W'(p_ir) - cau_pkg::SUM_W'(p_ri);
    fnext.den         = den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fout <= fnext;
    end
  end

endmodule

### hw/rtl/cau_div.sv
// ============================================================================
// Pipelined rounding divider
// Forms round(num * 2^FRAC_BITS / den), ties away from zero, one quotient bit
// per stage, with an overflow flag for quotients beyond the checked range.
// ============================================================================
module cau_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [cau_pkg::SUM_W-1:0] num,
  input  logic [cau_pkg::PROD_W-1:0]       den,
  output logic [cau_pkg::QBITS-1:0]        q,
  output logic                             neg,
  output logic                             ovf
);

  localparam int QB = cau_pkg::QBITS;

  logic [cau_pkg::REM_W-1:0]  rem   [0:QB];
  logic [QB-1:0]              qs    [0:QB];
  logic [cau_pkg::PROD_W-1:0] den_s [0:QB];
  logic                       neg_s [0:QB];
  logic                       ovf_s [0:QB];

  logic [cau_pkg::PROD_W-1:0] mag;
  logic [cau_pkg::NUM_W-1:0]  n_sc;

  // Magnitude, scaling and the half-divisor rounding term.
  always_comb begin
    mag  = num[cau_pkg::SUM_W-1] ? cau_pkg::PROD_W'(-num) : cau_pkg::PROD_W'(num);
    n_sc = (cau_pkg::NUM_W'(mag) << cau_pkg::FRAC_BITS) + cau_pkg::NUM_W'(den >> 1);
  end

  // Preparation stage.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= cau_pkg::REM_W'(n_sc);
      qs[0]    <= '0;
      den_s[0] <= den;
      neg_s[0] <= num[cau_pkg::SUM_W-1];
      ovf_s[0] <= cau_pkg::REM_W'(n_sc) >= (cau_pkg::REM_W'(den) << QB);
    end
  end

  // Restoring division, most significant quotient bit first.
  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [cau_pkg::REM_W-1:0] dsh;
    logic                      take;
    assign dsh  = cau_pkg::REM_W'(den_s[i]) << (QB - 1 - i);
    assign take = rem[i] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]   <= take ? rem[i] - dsh : rem[i];
        qs[i+1]    <= qs[i] | (QB'(take) << (QB - 1 - i));
        den_s[i+1] <= den_s[i];
        neg_s[i+1] <= neg_s[i];
        ovf_s[i+1] <= ovf_s[i];
      end
    end
  end

  assign q   = qs[QB];
  assign neg = neg_s[QB];
  assign ovf = ovf_s[QB];

endmodule

### hw/rtl/cau_sqrt.sv
// ============================================================================
// Pipelined rounding square root
// Digit-by-digit integer square root, one result bit per stage, followed by
// a round-to-nearest stage.
// ============================================================================
module cau_sqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [cau_pkg::PROD_W-1:0]       x,
  output logic [cau_pkg::DATA_WIDTH-1:0]   root
);

  localparam int NS = cau_pkg::DATA_WIDTH;
  localparam int RW = cau_pkg::PROD_W + 1;

  logic [RW-1:0] rem [0:NS];
  logic [RW-1:0] r   [0:NS];

  // Load stage.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(x);
      r[0]   <= '0;
    end
  end

  // One root bit per stage; the trial bit walks down by powers of four.
  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [RW-1:0] bitv;
    logic [RW-1:0] trial;
    logic          take;
    assign bitv  = RW'(1) << (cau_pkg::PROD_W - 2 - 2 * j);
    assign trial = r[j] + bitv;
    assign take  = rem[j] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= take ? rem[j] - trial : rem[j];
        r[j+1]   <= take ? (r[j] >> 1) + bitv : r[j] >> 1;
      end
    end
  end

  // Round up when the remainder exceeds the root.
  always_ff @(posedge clk) begin
    if (en) begin
      root <= cau_pkg::DATA_WIDTH'(r[NS] + RW'(rem[NS] > r[NS]));
    end
  end

endmodule

### hw/rtl/complex_arithmetic_unit_core.sv
// ============================================================================
// Complex arithmetic unit
// Add, subtract, multiply, divide, conjugate and modulus on Q8.8 complex
// operands, in a stall-together pipeline with saturation and status.
// ============================================================================
// Stages in order: input register, front end, divider, output register.
// Throughput: one item per cycle unless the output stalls; the divider and
// square root each retire one quotient or root bit per stage, setting the depth.
// A stall on the output freezes every stage together.
// Reset clears all stage valid bits; data registers are not reset.
module complex_arithmetic_unit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // a_re, a_im, b_re, b_im
  input  logic [2:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // res_re, res_im
  output logic [1:0]  m_tuser    // status
);

  localparam int DW  = cau_pkg::DATA_WIDTH;
  localparam int DLY = cau_pkg::DIV_LAT;
  localparam int NST = 4 + DLY;

  logic              en;
  logic [NST-1:0]    vld;
  logic [2:0]        op0;
  logic signed [DW-1:0] ar0, ai0, br0, bi0;

  // The whole pipeline advances unless a finished result is held.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (en) begin
      op0 <= s_tuser;
      ar0 <= s_tdata[DW-1:0];
      ai0 <= s_tdata[2*DW-1:DW];
      br0 <= s_tdata[3*DW-1:2*DW];
      bi0 <= s_tdata[4*DW-1:3*DW];
    end
  end

  cau_pkg::front_out_t fout;

  cau_front u_front (
    .clk  (clk),
    .en   (en),
    .op   (op0),
    .ar   (ar0),
    .ai   (ai0),
    .br   (br0),
    .bi   (bi0),
    .fout (fout)
  );

  logic [cau_pkg::QBITS-1:0] q_re, q_im;
  logic                      neg_re, neg_im, ovf_re, ovf_im;
  logic [DW-1:0]             root;

  cau_div u_div_re (
    .clk (clk), .en (en), .num (fout.num_re), .den (fout.den),
    .q (q_re), .neg (neg_re), .ovf (ovf_re)
  );

  cau_div u_div_im (
    .clk (clk), .en (en), .num (fout.num_im), .den (fout.den),
    .q (q_im), .neg (neg_im), .ovf (ovf_im)
  );

  cau_sqrt u_sqrt (
    .clk (clk), .en (en), .x (fout.den), .root (root)
  );

  // Delay line that keeps the simple results beside the divider.
  cau_pkg::simple_t dly [0:DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= fout.simple;
      for (int k = 1; k < DLY; k++) begin
        dly[k] <= dly[k-1];
      end
    end
  end

  cau_pkg::sat_t                       d_re, d_im, m_sat;
  logic signed [DW-1:0]                res_re_next, res_im_next;
  logic [1:0]                          st_next;
  logic                                clip;
  logic [2:0]                          op_out;
  cau_pkg::simple_t                    sl;

  // Saturate a divider quotient by its sign.
  function automatic cau_pkg::sat_t div_sat(input logic [cau_pkg::QBITS-1:0] qv,
                                            input logic ng, input logic ov);
    cau_pkg::sat_t s;
    logic signed [cau_pkg::SAT_IN_W-1:0] qw;
    qw = cau_pkg::SAT_IN_W'(qv);
    if (!ng) begin
      if (ov || qw > cau_pkg::VAL_MAX) begin
        s.val = cau_pkg::VAL_MAX[DW-1:0];
        s.clip = 1'b1;
      end else begin
        s.val = qw[DW-1:0];
        s.clip = 1'b0;
      end
    end else begin
      if (ov || qw > -cau_pkg::VAL_MIN) begin
        s.val = cau_pkg::VAL_MIN[DW-1:0];
        s.clip = 1'b1;
      end else begin
        s.val = DW'(-qw);
        s.clip = 1'b0;
      end
    end
    return s;
  endfunction

  // Result select, final saturation and status.
  always_comb begin
    sl          = dly[DLY-1];
    d_re        = div_sat(q_re, neg_re, ovf_re);
    d_im        = div_sat(q_im, neg_im, ovf_im);
    m_sat       = cau_pkg::sat(cau_pkg::SAT_IN_W'({1'b0, root}));
    res_re_next = sl.re;
    res_im_next = sl.im;
    clip        = sl.clip;
    st_next     = cau_pkg::ST_OK;
    case (sl.op)
      cau_pkg::OP_DIV: begin
        if (sl.dz) begin
          res_re_next = '0;
          res_im_next = '0;
          clip        = 1'b0;
          st_next     = cau_pkg::ST_DZ;
        end else begin
          res_re_next = d_re.val;
          res_im_next = d_im.val;
          clip        = d_re.clip | d_im.clip;
        end
      end
      cau_pkg::OP_MOD: begin
        res_re_next = m_sat.val;
        res_im_next = '0;
        clip        = m_sat.clip;
      end
      default: begin
        res_re_next = sl.re;
        res_im_next = sl.im;
        clip        = sl.clip;
      end
    endcase
    if (st_next == cau_pkg::ST_OK && clip) begin
      st_next = cau_pkg::ST_SAT;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {res_im_next, res_re_next};
      m_tuser <= st_next;
      op_out  <= sl.op;
    end
  end

  assign m_tvalid = vld[NST-1];

  // A division by zero returns both parts as zero.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == cau_pkg::ST_DZ |-> m_tdata == '0)
    else $error("division by zero result is not zero");

  // The modulus always has a zero imaginary part and no division status.
  a_mod_im: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && op_out == cau_pkg::OP_MOD |-> m_tdata[2*DW-1:DW] == '0 &&
    m_tuser != cau_pkg::ST_DZ)
    else $error("modulus result malformed");

  // Only a divide can report a division by zero.
  a_dz_op: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == cau_pkg::ST_DZ |-> op_out == cau_pkg::OP_DIV)
    else $error("division status on another operation");

  // Nothing leaves the pipeline right after reset.
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule
